@@ design/epwt_pkg.sv @@
// Package for the echo pulse width timer core.
// Holds the command codes, field widths and reset constants.
// No dependencies.
`timescale 1ns / 1ps

package epwt_pkg;

    localparam int unsigned SENSOR_COUNT_DEF = 4;
    localparam int unsigned SENSOR_COUNT_MAX = 16;
    localparam int unsigned IDX_W            = 2;
    localparam int unsigned TIME_W           = 32;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd50000;

    typedef enum logic {
        CMD_TRIGGER = 1'b0,
        CMD_ECHO    = 1'b1
    } cmd_t;

endpackage

@@ design/echo_pulse_width_timer_core.sv @@
// Echo pulse width timer core: per-sensor trigger/echo bookkeeping.
// Depends on epwt_pkg.
`timescale 1ns / 1ps

// Usage:
//   in channel  (in_valid/in_ready): one event item per handshake, either a
//     trigger request or a captured echo edge for one sensor, with timestamp.
//   out channel (out_valid/out_ready): exactly one result item per event,
//     in event order, reporting the sensor's state after the event.
//   cfg channel (cfg_valid/cfg_ready): writes echo_timeout; always ready.
//     Write it only while no event is in flight.
// Path: an accepted event is held in the input register, then its result is
//   offered from the result register.
// Throughput: 1 item per cycle unless stalled. The per-sensor state is read and
//   written in the single stage between the input and result registers, so a
//   following event on the same sensor sees the update with no bubble.
// Stall: while a result waits on out_ready, the input register holds one more
//   event; after that in_ready drops until the result is taken.
// Reset: all sensors idle, no echo, widths zero, echo_timeout = 50000,
//   both registers empty.
module echo_pulse_width_timer_core
    import epwt_pkg::*;
#(
    parameter int unsigned SENSOR_COUNT = SENSOR_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TIME_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic [IDX_W-1:0]  sensor_index,
    input  logic [TIME_W-1:0] time_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [IDX_W-1:0]  sensor_id,
    output logic              fire_trigger,
    output logic [TIME_W-1:0] pulse_width,
    output logic              reading_ready,
    output logic              sensor_status,
    output logic              await_falling
);

    localparam int unsigned SEL_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    logic [TIME_W-1:0] timeout_reg;

    logic              stg_valid_reg;
    cmd_t              stg_cmd_reg;
    logic [IDX_W-1:0]  stg_idx_reg;
    logic [TIME_W-1:0] stg_time_reg;

    logic              meas_reg   [SENSOR_COUNT];
    logic              rise_reg   [SENSOR_COUNT];
    logic [TIME_W-1:0] rtime_reg  [SENSOR_COUNT];
    logic [TIME_W-1:0] trig_reg   [SENSOR_COUNT];
    logic [TIME_W-1:0] width_reg  [SENSOR_COUNT];
    logic              ready_reg  [SENSOR_COUNT];
    logic              status_reg [SENSOR_COUNT];

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_id_reg;
    logic              out_fire_reg;
    logic [TIME_W-1:0] out_width_reg;
    logic              out_ready_flag_reg;
    logic              out_status_reg;
    logic              out_await_reg;

    logic              advance;
    logic              in_range;
    logic [SEL_W-1:0]  sel;
    logic [TIME_W-1:0] elapsed;
    logic              expired;

    logic              meas_next;
    logic              rise_next;
    logic [TIME_W-1:0] rtime_next;
    logic [TIME_W-1:0] trig_next;
    logic [TIME_W-1:0] width_next;
    logic              ready_next;
    logic              status_next;
    logic              fire_next;

    assign cfg_ready = 1'b1;
    assign advance   = stg_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stg_valid_reg || advance;

    assign in_range = (32'(stg_idx_reg) < 32'(SENSOR_COUNT));
    assign sel      = SEL_W'(stg_idx_reg);
    assign elapsed  = stg_time_reg - trig_reg[sel];
    assign expired  = elapsed > timeout_reg;

    always_comb
    begin
        meas_next   = meas_reg[sel];
        rise_next   = rise_reg[sel];
        rtime_next  = rtime_reg[sel];
        trig_next   = trig_reg[sel];
        width_next  = width_reg[sel];
        ready_next  = ready_reg[sel];
        status_next = status_reg[sel];
        fire_next   = 1'b0;
        case (stg_cmd_reg)
            CMD_TRIGGER:
            begin
                if (meas_reg[sel] && expired)
                begin
                    width_next  = '0;
                    status_next = 1'b0;
                    rise_next   = 1'b0;
                end
                if (!meas_reg[sel] || expired)
                begin
                    ready_next = 1'b0;
                    trig_next  = stg_time_reg;
                    meas_next  = 1'b1;
                    fire_next  = 1'b1;
                end
            end
            CMD_ECHO:
            begin
                if (meas_reg[sel])
                begin
                    if (!rise_reg[sel])
                    begin
                        rtime_next  = stg_time_reg;
                        rise_next   = 1'b1;
                        status_next = 1'b1;
                    end
                    else
                    begin
                        width_next = stg_time_reg - rtime_reg[sel];
                        ready_next = 1'b1;
                        rise_next  = 1'b0;
                        meas_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                fire_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stg_cmd_reg  <= cmd_t'(command);
            stg_idx_reg  <= sensor_index;
            stg_time_reg <= time_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SENSOR_COUNT; k++)
            begin
                meas_reg[k]   <= 1'b0;
                rise_reg[k]   <= 1'b0;
                rtime_reg[k]  <= '0;
                trig_reg[k]   <= '0;
                width_reg[k]  <= '0;
                ready_reg[k]  <= 1'b0;
                status_reg[k] <= 1'b0;
            end
        end
        else if (advance && in_range)
        begin
            meas_reg[sel]   <= meas_next;
            rise_reg[sel]   <= rise_next;
            rtime_reg[sel]  <= rtime_next;
            trig_reg[sel]   <= trig_next;
            width_reg[sel]  <= width_next;
            ready_reg[sel]  <= ready_next;
            status_reg[sel] <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_id_reg         <= stg_idx_reg;
            out_fire_reg       <= in_range && fire_next;
            out_width_reg      <= in_range ? width_next : '0;
            out_ready_flag_reg <= in_range && ready_next;
            out_status_reg     <= in_range && status_next;
            out_await_reg      <= in_range && meas_next && rise_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sensor_id     = out_id_reg;
    assign fire_trigger  = out_fire_reg;
    assign pulse_width   = out_width_reg;
    assign reading_ready = out_ready_flag_reg;
    assign sensor_status = out_status_reg;
    assign await_falling = out_await_reg;

endmodule

@@ design/epwt_checker.sv @@
// Port-level checks for the echo pulse width timer core, bound to the top.
// Depends on epwt_pkg and echo_pulse_width_timer_core.
`timescale 1ns / 1ps

module epwt_checker
    import epwt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [IDX_W-1:0]  sensor_id,
    input logic              fire_trigger,
    input logic [TIME_W-1:0] pulse_width,
    input logic              reading_ready,
    input logic              sensor_status,
    input logic              await_falling
);

    // stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sensor_id)
            && $stable(pulse_width) && $stable(reading_ready))
        else $error("stalled result item changed");

    // a fresh trigger clears ready and any pending rise
    a_fire_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fire_trigger |-> !reading_ready && !await_falling)
        else $error("trigger result with ready or pending falling edge");

    // a pending falling edge implies the rise already set status ok
    a_await_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && await_falling |-> sensor_status)
        else $error("awaiting falling edge without ok status");

    // a completed width leaves the sensor idle
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reading_ready |-> !await_falling && !fire_trigger)
        else $error("ready width with sensor still active");

endmodule

bind echo_pulse_width_timer_core epwt_checker u_epwt_checker (.*);
